// File: rtl/core/etc_pkg.sv
// Shared types and constants for the encoder tuning controller.
// Used by etc_update and encoder_tuning_controller_core; no dependencies.
`timescale 1ns / 1ps

package etc_pkg;

    // Field widths fixed by the interface
    localparam int FIELD_W    = 27;
    localparam int STEP_LIM_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    localparam int FREQ_BITS_DEF = 27;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IF_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BTN_LEVEL  = 2'd3;

    // Register reset values
    localparam logic [FIELD_W-1:0]    FREQ_LIMIT_RST = 27'd70000000;
    localparam logic [FIELD_W-1:0]    IF_LIMIT_RST   = 27'd20000000;
    localparam logic [STEP_LIM_W-1:0] STEP_LIMIT_RST = 24'd1000000;
    localparam logic                  BTN_LEVEL_RST  = 1'b0;

    // Menu modes
    localparam logic [1:0] MODE_TUNE = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_IF   = 2'd2;
    localparam logic [1:0] MODE_VFO  = 2'd3;

    // VFO kinds; the reserved code is never produced
    localparam logic [1:0] KIND_DIRECT   = 2'd0;
    localparam logic [1:0] KIND_IF_PLUS  = 2'd1;
    localparam logic [1:0] KIND_IF_MINUS = 2'd2;
    localparam logic [1:0] KIND_RSVD     = 2'd3;

    // Phase pairs {b, a}
    localparam logic [1:0] PH_00 = 2'd0;
    localparam logic [1:0] PH_01 = 2'd1;
    localparam logic [1:0] PH_10 = 2'd2;
    localparam logic [1:0] PH_11 = 2'd3;

    // Divide by ten: q = (x * ceil(2^35 / 10)) >> 35, exact for any 32-bit x
    localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          TEN         = 10;

    typedef struct packed {
        logic button;
        logic phase_b;
        logic phase_a;
    } t_pins;

    typedef struct packed {
        logic [FIELD_W-1:0]    freq_limit;
        logic [FIELD_W-1:0]    if_limit;
        logic [STEP_LIM_W-1:0] step_limit;
        logic                  button_on_level;
    } t_cfg;

endpackage

// File: rtl/core/encoder_tuning_controller_core.sv
// Top level of the encoder tuning controller: config registers, state and
// result register, valid/stall handshakes. Uses etc_pkg and etc_update.
`timescale 1ns / 1ps

// One pin-sample word is taken per clock and its result word appears in the
// next cycle: the update is a single pass of combinational logic from the
// held state to the state registers, which are also the result register.
// Sustained rate is one word per cycle; the input stalls only while a result
// waits and the output side stalls. Config writes apply at once and should
// be made while no result is pending.
module encoder_tuning_controller_core #(
    parameter int FREQ_BITS = etc_pkg::FREQ_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [etc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [etc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_phase_a,
    input  logic                           i_phase_b,
    input  logic                           i_button,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [etc_pkg::FIELD_W-1:0]    o_frequency_out,
    output logic [etc_pkg::FIELD_W-1:0]    o_if_frequency_out,
    output logic [etc_pkg::FIELD_W-1:0]    o_step_out,
    output logic [1:0]                     o_menu_mode_out,
    output logic [1:0]                     o_vfo_kind_out
);

    etc_pkg::t_cfg  r_cfg;
    etc_pkg::t_pins r_prev;
    etc_pkg::t_pins now_pins;
    logic [1:0]           r_mode;
    logic [1:0]           r_kind;
    logic [FREQ_BITS-1:0] r_dial;
    logic [FREQ_BITS-1:0] r_inter;
    logic [FREQ_BITS-1:0] r_step;
    logic                 r_out_valid;
    logic [1:0]           n_mode;
    logic [1:0]           n_kind;
    logic [FREQ_BITS-1:0] n_dial;
    logic [FREQ_BITS-1:0] n_inter;
    logic [FREQ_BITS-1:0] n_step;
    logic                 n_out_valid;
    logic                 in_acc;

    assign now_pins   = '{button: i_button, phase_b: i_phase_b, phase_a: i_phase_a};
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    etc_update #(
        .FREQ_BITS (FREQ_BITS)
    ) u_update (
        .i_cfg   (r_cfg),
        .i_prev  (r_prev),
        .i_now   (now_pins),
        .i_mode  (r_mode),
        .i_kind  (r_kind),
        .i_dial  (r_dial),
        .i_inter (r_inter),
        .i_step  (r_step),
        .o_mode  (n_mode),
        .o_kind  (n_kind),
        .o_dial  (n_dial),
        .o_inter (n_inter),
        .o_step  (n_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_limit      <= etc_pkg::FREQ_LIMIT_RST;
            r_cfg.if_limit        <= etc_pkg::IF_LIMIT_RST;
            r_cfg.step_limit      <= etc_pkg::STEP_LIMIT_RST;
            r_cfg.button_on_level <= etc_pkg::BTN_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                etc_pkg::REG_FREQ_LIMIT: r_cfg.freq_limit <= i_cfg_data[etc_pkg::FIELD_W-1:0];
                etc_pkg::REG_IF_LIMIT:   r_cfg.if_limit   <= i_cfg_data[etc_pkg::FIELD_W-1:0];
                etc_pkg::REG_STEP_LIMIT: begin
                    r_cfg.step_limit <= i_cfg_data[etc_pkg::STEP_LIM_W-1:0];
                end
                etc_pkg::REG_BTN_LEVEL:  r_cfg.button_on_level <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // word is taken when the consumer is not stalling, or a new one replaces it
    always_comb begin
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_mode      <= etc_pkg::MODE_TUNE;
            r_kind      <= etc_pkg::KIND_DIRECT;
            r_dial      <= '0;
            r_inter     <= '0;
            r_step      <= FREQ_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_prev  <= now_pins;
                r_mode  <= n_mode;
                r_kind  <= n_kind;
                r_dial  <= n_dial;
                r_inter <= n_inter;
                r_step  <= n_step;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frequency_out    = etc_pkg::FIELD_W'(r_dial);
    assign o_if_frequency_out = etc_pkg::FIELD_W'(r_inter);
    assign o_step_out         = etc_pkg::FIELD_W'(r_step);
    assign o_menu_mode_out    = r_mode;
    assign o_vfo_kind_out     = r_kind;

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> ($stable(r_dial) && $stable(r_inter) && $stable(r_step) &&
                     $stable(r_mode) && $stable(r_kind)))
        else $error("state changed without an accepted word");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted word produced no result");

    a_mode_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_mode == $past(r_mode) || r_mode == 2'($past(r_mode) + 2'd1)))
        else $error("menu mode skipped a step");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind != etc_pkg::KIND_RSVD)
        else $error("VFO kind reached the reserved code");

endmodule

// File: rtl/core/etc_update.sv
// Next-state logic of the encoder tuning controller: turn and press
// detection, saturating frequency moves, step scaling, VFO rotation. Uses etc_pkg.
`timescale 1ns / 1ps

module etc_update #(
    parameter int FREQ_BITS = etc_pkg::FREQ_BITS_DEF
) (
    input  etc_pkg::t_cfg        i_cfg,
    input  etc_pkg::t_pins       i_prev,
    input  etc_pkg::t_pins       i_now,
    input  logic [1:0]           i_mode,
    input  logic [1:0]           i_kind,
    input  logic [FREQ_BITS-1:0] i_dial,
    input  logic [FREQ_BITS-1:0] i_inter,
    input  logic [FREQ_BITS-1:0] i_step,
    output logic [1:0]           o_mode,
    output logic [1:0]           o_kind,
    output logic [FREQ_BITS-1:0] o_dial,
    output logic [FREQ_BITS-1:0] o_inter,
    output logic [FREQ_BITS-1:0] o_step
);

    localparam int FB = FREQ_BITS;
    // compare width for sum against a 27-bit limit
    localparam int CW = (FB + 1 > etc_pkg::FIELD_W) ? FB + 1 : etc_pkg::FIELD_W;
    // compare width for the step against the step limit
    localparam int SW = (FB > etc_pkg::STEP_LIM_W) ? FB : etc_pkg::STEP_LIM_W;
    localparam int TW = FB + 4;
    localparam logic [FB-1:0] VAL_MAX = {FB{1'b1}};

    function automatic logic [FB-1:0] add_sat(input logic [FB-1:0] v,
                                              input logic [FB-1:0] s,
                                              input logic [CW-1:0] lim);
        logic [CW-1:0] sum;
        logic [CW-1:0] sat;
        sum = CW'(v) + CW'(s);
        sat = (sum < lim) ? sum : lim;
        return (sat > CW'(VAL_MAX)) ? VAL_MAX : FB'(sat);
    endfunction

    function automatic logic [FB-1:0] sub_floor(input logic [FB-1:0] v,
                                                input logic [FB-1:0] s);
        return (v > s) ? (v - s) : '0;
    endfunction

    logic [1:0]    pp;
    logic [1:0]    pn;
    logic          left;
    logic          right;
    logic          press;
    logic [1:0]    mode;
    logic [FB-1:0] dial_up_lim;
    logic [FB-1:0] dial_up_inter;
    logic [FB-1:0] dial_down;
    logic [FB-1:0] inter_up;
    logic [FB-1:0] inter_down;
    logic [TW-1:0] times10;
    logic [63:0]   div_prod;
    logic [31:0]   div_q;
    logic [SW-1:0] lim_ext;
    logic [FB-1:0] lim_clamped;
    logic [FB-1:0] step_up;
    logic [FB-1:0] step_down;

    always_comb begin
        pp = {i_prev.phase_b, i_prev.phase_a};
        pn = {i_now.phase_b, i_now.phase_a};
        left  = (pp == etc_pkg::PH_00 && pn == etc_pkg::PH_01) ||
                (pp == etc_pkg::PH_11 && pn == etc_pkg::PH_10);
        right = (pp == etc_pkg::PH_10 && pn == etc_pkg::PH_11) ||
                (pp == etc_pkg::PH_01 && pn == etc_pkg::PH_00);
        press = (i_now.button == i_cfg.button_on_level) &&
                (i_prev.button != i_cfg.button_on_level);
        // mode change lands before the turn of the same word
        mode = i_mode + 2'(press);

        dial_up_lim   = add_sat(i_dial, i_step, CW'(i_cfg.freq_limit));
        dial_up_inter = add_sat(i_dial, i_step, CW'(i_inter));
        dial_down     = sub_floor(i_dial, i_step);
        inter_up      = add_sat(i_inter, i_step, CW'(i_cfg.if_limit));
        inter_down    = sub_floor(i_inter, i_step);

        times10  = (TW'(i_step) << 3) + (TW'(i_step) << 1);
        div_prod = 64'(32'(i_step)) * 64'(etc_pkg::DIV10_MUL);
        div_q    = 32'(div_prod >> etc_pkg::DIV10_SHIFT);
        lim_ext  = SW'(i_cfg.step_limit);
        lim_clamped = (lim_ext > SW'(VAL_MAX)) ? VAL_MAX : FB'(lim_ext);

        if (SW'(i_step) < lim_ext) begin
            step_up = (times10 > TW'(VAL_MAX)) ? VAL_MAX : FB'(times10);
        end else begin
            step_up = FB'(1);
        end
        if (i_step >= FB'(etc_pkg::TEN)) begin
            step_down = FB'(div_q);
        end else begin
            step_down = lim_clamped;
        end

        o_mode  = mode;
        o_kind  = i_kind;
        o_dial  = i_dial;
        o_inter = i_inter;
        o_step  = i_step;

        case (mode)
            etc_pkg::MODE_TUNE: begin
                if (i_kind == etc_pkg::KIND_DIRECT || i_kind == etc_pkg::KIND_IF_PLUS) begin
                    if (left)  o_dial = dial_up_lim;
                    if (right) o_dial = dial_down;
                end else if (i_kind == etc_pkg::KIND_IF_MINUS) begin
                    if (left)  o_dial = dial_down;
                    if (right) o_dial = dial_up_inter;
                end
            end
            etc_pkg::MODE_STEP: begin
                if (left)  o_step = step_up;
                if (right) o_step = step_down;
            end
            etc_pkg::MODE_IF: begin
                if (left)  o_inter = inter_up;
                if (right) o_inter = inter_down;
            end
            etc_pkg::MODE_VFO: begin
                if (i_kind != etc_pkg::KIND_RSVD) begin
                    if (left) begin
                        o_kind = (i_kind == etc_pkg::KIND_IF_MINUS) ?
                                 etc_pkg::KIND_DIRECT : i_kind + 2'd1;
                    end
                    if (right) begin
                        o_kind = (i_kind == etc_pkg::KIND_DIRECT) ?
                                 etc_pkg::KIND_IF_MINUS : i_kind - 2'd1;
                    end
                end
            end
            default: begin
                o_mode = mode;
            end
        endcase
    end

endmodule
